// ----- hdl/lhr_pkg.sv -----
// lhr_pkg: shared types and codes of the line history ring
// payload structs of both channels, the front-to-back command and the status/mode codes
// no dependencies

package lhr_pkg;

    // request modes
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_OLDER = 2'd1;
    localparam logic [1:0] MODE_NEWER = 2'd2;
    localparam logic [1:0] MODE_RESET = 2'd3;

    // result status codes
    localparam logic [2:0] ST_TEXT   = 3'd0;
    localparam logic [2:0] ST_NONE   = 3'd1;
    localparam logic [2:0] ST_ADDED  = 3'd2;
    localparam logic [2:0] ST_DUP    = 3'd3;
    localparam logic [2:0] ST_REJECT = 3'd4;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] ch;
        logic       has_char;
        logic       end_of_line;
        logic [4:0] nav_in;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] ch_out;
        logic       has_char_out;
        logic       last_out;
        logic [4:0] nav_out;
        logic [4:0] entries_out;
    } out_item_t;

    // command queued from front to back
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] ch;
        logic       stage_ch;
        logic       eol;
        logic [4:0] nav;
    } cmd_t;

endpackage

// ----- hdl/lhr_front.sv -----
// lhr_front: input side of the line history ring
// accepts items, drops those with no effect, and queues commands for the back end
// depends on lhr_pkg

module lhr_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  lhr_pkg::in_item_t req,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output lhr_pkg::cmd_t     cmd
);

    lhr_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    fill_reg;
    logic          keep;
    logic          push;
    logic          pop;
    logic          stage_ch;
    lhr_pkg::cmd_t new_cmd;

    // classify: characters of mode add/older are staged, line ends always act
    assign stage_ch = req.has_char &&
                      (req.mode == lhr_pkg::MODE_ADD || req.mode == lhr_pkg::MODE_OLDER);
    assign keep     = stage_ch || req.end_of_line;

    always_comb
    begin
        new_cmd.mode     = req.mode;
        new_cmd.ch       = req.ch;
        new_cmd.stage_ch = stage_ch;
        new_cmd.eol      = req.end_of_line;
        new_cmd.nav      = req.nav_in;
    end

    assign req_ready = (fill_reg != 2'd2);
    assign push      = req_valid && req_ready && keep;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    // two-entry command queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= new_cmd;
    end

endmodule

// ----- hdl/lhr_back.sv -----
// lhr_back: execution side of the line history ring
// owns the slot, staging and parked memories and sequences add, recall and reset
// depends on lhr_pkg

module lhr_back
#(
    parameter int SLOTS = 16,
    parameter int LINE  = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  lhr_pkg::cmd_t      cmd,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output lhr_pkg::out_item_t rsp
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IW = $clog2(LINE);
    localparam int LW = $clog2(LINE + 1);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int NW = 8;

    typedef enum logic [14:0] {
        S_IDLE     = 15'd1,
        S_LEN_RD   = 15'd2,
        S_LEN_CHK  = 15'd4,
        S_CMP_RD   = 15'd8,
        S_CMP_CHK  = 15'd16,
        S_CPY_RD   = 15'd32,
        S_CPY_WR   = 15'd64,
        S_PARK_RD  = 15'd128,
        S_PARK_WR  = 15'd256,
        S_MOD      = 15'd512,
        S_ELEN_RD  = 15'd1024,
        S_ELEN_CHK = 15'd2048,
        S_EMIT_RD  = 15'd4096,
        S_EMIT_OUT = 15'd8192,
        S_RESULT   = 15'd16384
    } state_t;

    // memories
    logic [7:0]    slot_text [SLOTS][LINE];
    logic [IW-1:0] slot_len  [SLOTS];
    logic [7:0]    stg_text  [LINE];
    logic [7:0]    park_text [LINE];

    logic [7:0]    slot_rd;
    logic [IW-1:0] len_rd;
    logic [7:0]    stg_rd;
    logic [7:0]    park_rd;

    state_t        state_reg, state_next;
    logic [LW-1:0] slen_reg, slen_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] head_reg, head_next;
    logic [IW-1:0] park_len_reg, park_len_next;
    logic [IW-1:0] len_reg, len_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [SW-1:0] sel_reg, sel_next;
    logic [NW-1:0] navw_reg, navw_next;
    logic [4:0]    nav_reg, nav_next;
    logic          src_park_reg, src_park_next;
    logic [2:0]    res_status_reg, res_status_next;
    logic          out_valid_reg;
    lhr_pkg::out_item_t out_reg;

    logic               out_free;
    logic               out_load;
    lhr_pkg::out_item_t out_data;
    logic               stg_we;
    logic               park_we;
    logic               slot_we;
    logic               slen_we;
    logic               stage;
    logic [LW-1:0]      slen_cur;
    logic [NW-1:0]      head_ext;
    logic               idx_last;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign cmd_ready = (state_reg == S_IDLE);
    assign stage     = cmd.stage_ch && (slen_reg < LW'(LINE));
    assign slen_cur  = slen_reg + LW'(stage);
    assign head_ext  = NW'(head_reg);
    assign idx_last  = (idx_reg == len_reg - IW'(1));

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        slen_next       = slen_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        park_len_next   = park_len_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        sel_next        = sel_reg;
        navw_next       = navw_reg;
        nav_next        = nav_reg;
        src_park_next   = src_park_reg;
        res_status_next = res_status_reg;
        stg_we          = 1'b0;
        park_we         = 1'b0;
        slot_we         = 1'b0;
        slen_we         = 1'b0;
        out_load        = 1'b0;
        out_data.status       = lhr_pkg::ST_TEXT;
        out_data.ch_out       = src_park_reg ? park_rd : slot_rd;
        out_data.has_char_out = 1'b1;
        out_data.last_out     = idx_last;
        out_data.nav_out      = nav_reg;
        out_data.entries_out  = 5'(count_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    stg_we    = stage;
                    slen_next = slen_cur;
                    if (cmd.eol)
                    begin
                        slen_next     = '0;
                        nav_next      = cmd.nav;
                        idx_next      = '0;
                        src_park_next = 1'b0;
                        case (cmd.mode)
                            lhr_pkg::MODE_ADD:
                            begin
                                if (slen_cur == '0 || slen_cur >= LW'(LINE))
                                begin
                                    res_status_next = lhr_pkg::ST_REJECT;
                                    state_next      = S_RESULT;
                                end
                                else
                                begin
                                    len_next = slen_cur[IW-1:0];
                                    if (count_reg != '0)
                                    begin
                                        sel_next   = (head_reg == '0) ? SW'(SLOTS - 1)
                                                                      : head_reg - SW'(1);
                                        state_next = S_LEN_RD;
                                    end
                                    else
                                    begin
                                        sel_next   = head_reg;
                                        state_next = S_CPY_RD;
                                    end
                                end
                            end
                            lhr_pkg::MODE_OLDER:
                            begin
                                if (NW'(cmd.nav) >= NW'(count_reg))
                                begin
                                    res_status_next = lhr_pkg::ST_NONE;
                                    state_next      = S_RESULT;
                                end
                                else
                                begin
                                    navw_next  = NW'(cmd.nav) + NW'(1);
                                    nav_next   = cmd.nav + 5'd1;
                                    state_next = S_MOD;
                                    if (cmd.nav == 5'd0)
                                    begin
                                        // park the live line, cut to LINE-1 characters
                                        if (slen_cur > LW'(LINE - 1))
                                            park_len_next = IW'(LINE - 1);
                                        else
                                            park_len_next = slen_cur[IW-1:0];
                                        if (slen_cur != '0)
                                        begin
                                            len_next   = (slen_cur > LW'(LINE - 1))
                                                         ? IW'(LINE - 1) : slen_cur[IW-1:0];
                                            state_next = S_PARK_RD;
                                        end
                                    end
                                end
                            end
                            lhr_pkg::MODE_NEWER:
                            begin
                                if (cmd.nav == 5'd0)
                                begin
                                    res_status_next = lhr_pkg::ST_NONE;
                                    state_next      = S_RESULT;
                                end
                                else if (cmd.nav == 5'd1)
                                begin
                                    nav_next      = 5'd0;
                                    src_park_next = 1'b1;
                                    len_next      = park_len_reg;
                                    if (park_len_reg == '0)
                                    begin
                                        res_status_next = lhr_pkg::ST_TEXT;
                                        state_next      = S_RESULT;
                                    end
                                    else
                                        state_next = S_EMIT_RD;
                                end
                                else
                                begin
                                    nav_next   = cmd.nav - 5'd1;
                                    navw_next  = NW'(cmd.nav) - NW'(1);
                                    state_next = S_MOD;
                                end
                            end
                            default:
                            begin
                                count_next      = '0;
                                head_next       = '0;
                                res_status_next = lhr_pkg::ST_NONE;
                                state_next      = S_RESULT;
                            end
                        endcase
                    end
                end
            end
            S_LEN_RD:
                state_next = S_LEN_CHK;
            S_LEN_CHK:
            begin
                idx_next = '0;
                if (len_rd == len_reg)
                    state_next = S_CMP_RD;
                else
                begin
                    sel_next   = head_reg;
                    state_next = S_CPY_RD;
                end
            end
            S_CMP_RD:
                state_next = S_CMP_CHK;
            // compare staged line against the newest entry
            S_CMP_CHK:
            begin
                if (slot_rd != stg_rd)
                begin
                    sel_next   = head_reg;
                    idx_next   = '0;
                    state_next = S_CPY_RD;
                end
                else if (idx_last)
                begin
                    res_status_next = lhr_pkg::ST_DUP;
                    state_next      = S_RESULT;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_CMP_RD;
                end
            end
            S_CPY_RD:
                state_next = S_CPY_WR;
            // copy staged line into the head slot
            S_CPY_WR:
            begin
                slot_we = 1'b1;
                if (idx_last)
                begin
                    slen_we         = 1'b1;
                    head_next       = (head_reg == SW'(SLOTS - 1)) ? '0 : head_reg + SW'(1);
                    if (count_reg < CW'(SLOTS))
                        count_next = count_reg + CW'(1);
                    res_status_next = lhr_pkg::ST_ADDED;
                    state_next      = S_RESULT;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_CPY_RD;
                end
            end
            S_PARK_RD:
                state_next = S_PARK_WR;
            S_PARK_WR:
            begin
                park_we = 1'b1;
                if (idx_last)
                    state_next = S_MOD;
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_PARK_RD;
                end
            end
            // reduce depth modulo the ring size, then pick the slot
            S_MOD:
            begin
                if (navw_reg >= NW'(SLOTS))
                    navw_next = navw_reg - NW'(SLOTS);
                else
                begin
                    if (head_ext >= navw_reg)
                        sel_next = SW'(head_ext - navw_reg);
                    else
                        sel_next = SW'(head_ext + NW'(SLOTS) - navw_reg);
                    state_next = S_ELEN_RD;
                end
            end
            S_ELEN_RD:
                state_next = S_ELEN_CHK;
            S_ELEN_CHK:
            begin
                len_next = len_rd;
                idx_next = '0;
                if (len_rd == '0)
                begin
                    res_status_next = lhr_pkg::ST_TEXT;
                    state_next      = S_RESULT;
                end
                else
                    state_next = S_EMIT_RD;
            end
            S_EMIT_RD:
                state_next = S_EMIT_OUT;
            // one character per transfer
            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (idx_last)
                        state_next = S_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_RESULT:
            begin
                out_data.status       = res_status_reg;
                out_data.ch_out       = 8'd0;
                out_data.has_char_out = 1'b0;
                out_data.last_out     = 1'b1;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slen_reg       <= '0;
            count_reg      <= '0;
            head_reg       <= '0;
            park_len_reg   <= '0;
            len_reg        <= '0;
            idx_reg        <= '0;
            sel_reg        <= '0;
            navw_reg       <= '0;
            nav_reg        <= '0;
            src_park_reg   <= 1'b0;
            res_status_reg <= lhr_pkg::ST_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slen_reg       <= slen_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            park_len_reg   <= park_len_next;
            len_reg        <= len_next;
            idx_reg        <= idx_next;
            sel_reg        <= sel_next;
            navw_reg       <= navw_next;
            nav_reg        <= nav_next;
            src_park_reg   <= src_park_next;
            res_status_reg <= res_status_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= out_data;
    end

    // memory writes and registered reads
    always_ff @(posedge clk)
    begin
        if (stg_we)
            stg_text[slen_reg[IW-1:0]] <= cmd.ch;
        if (park_we)
            park_text[idx_reg] <= stg_rd;
        if (slot_we)
            slot_text[sel_reg][idx_reg] <= stg_rd;
        if (slen_we)
            slot_len[sel_reg] <= len_reg;
        slot_rd <= slot_text[sel_reg][idx_reg];
        len_rd  <= slot_len[sel_reg];
        stg_rd  <= stg_text[idx_reg];
        park_rd <= park_text[idx_reg];
    end

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        slen_reg <= LW'(LINE))
        else $error("staging length past line size");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOTS))
        else $error("entry count past ring size");

    assert property (@(posedge clk) disable iff (!rst_n)
        NW'(head_reg) < NW'(SLOTS))
        else $error("head slot out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_OUT) |-> (len_reg != '0))
        else $error("text emission with zero length");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result overwrote an untaken transfer");

endmodule

// ----- hdl/line_history_ring_unit.sv -----
// line_history_ring_unit: top level of the line history ring
// joins the accepting front end and the executing back end through a command queue
// depends on lhr_pkg, lhr_front, lhr_back

// A ring of SLOTS recorded lines of up to LINE-1 characters with older/newer recall.
// The back end takes a character item without leaving its idle state and the front queue
// holds two items, so characters stream in at one per cycle while no line-end sequence
// runs. A line end then runs a sequence on the text memories, each step a read followed
// by a use: adding a line reads the newest entry's length, compares the staged line with
// it character by character if the lengths match and, unless it is a duplicate, copies
// it into the head slot; a recall parks the live line (older from the live line only),
// reduces the depth modulo the ring size, picks the slot, reads its length and returns
// its characters. No clearing pass runs after reset.

module line_history_ring_unit
#(
    parameter int SLOTS = 16,
    parameter int LINE  = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  lhr_pkg::in_item_t  req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output lhr_pkg::out_item_t rsp
);

    logic          cmd_valid;
    logic          cmd_ready;
    lhr_pkg::cmd_t cmd;

    // accept and classify
    lhr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // execute
    lhr_back #(
        .SLOTS (SLOTS),
        .LINE  (LINE)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
